/* rtl/lcd_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and keyword lookup for the line command decoder.
// Used by the channel interfaces and the decoder top level.
package lcd_pkg;

  localparam int unsigned LineStoreDef = 128;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned LimitW    = 7;
  localparam int unsigned EventW    = 3;
  localparam int unsigned ValW      = 16;
  localparam int unsigned ModeW     = 8;
  localparam int unsigned NumFields = 5;
  localparam int unsigned FieldIdxW = 3;
  localparam int unsigned NumKw     = 5;

  localparam logic [LimitW-1:0] LimitReset = 7'd127;

  localparam logic [ByteW-1:0] ChCr    = 8'h0D;
  localparam logic [ByteW-1:0] ChLf    = 8'h0A;
  localparam logic [ByteW-1:0] ChSpace = 8'h20;
  localparam logic [ByteW-1:0] ChTab   = 8'h09;
  localparam logic [ByteW-1:0] ChComma = 8'h2C;
  localparam logic [ByteW-1:0] ChZero  = 8'h30;
  localparam logic [ByteW-1:0] ChNine  = 8'h39;

  typedef enum logic [EventW-1:0] {
    EvClear    = 3'd0,
    EvLoadDone = 3'd1,
    EvStart    = 3'd2,
    EvStop     = 3'd3,
    EvData     = 3'd4,
    EvBadData  = 3'd5,
    EvUnknown  = 3'd6,
    EvTooLong  = 3'd7
  } event_e;

  typedef enum logic [2:0] {
    KwClr      = 3'd0,
    KwLoadDone = 3'd1,
    KwStart    = 3'd2,
    KwStop     = 3'd3,
    KwData     = 3'd4
  } kw_e;

  // Keyword length in characters.
  function automatic logic [3:0] kw_len(input kw_e k);
    logic [3:0] len;
    case (k)
      KwClr:      len = 4'd3;
      KwLoadDone: len = 4'd9;
      KwStart:    len = 4'd5;
      KwStop:     len = 4'd4;
      KwData:     len = 4'd5;
      default:    len = 4'd0;
    endcase
    return len;
  endfunction

  // True when character c matches keyword k at position p.
  function automatic logic kw_hit(input kw_e k, input logic [7:0] p, input logic [7:0] c);
    logic [71:0] txt;
    logic [71:0] sh;
    logic [3:0]  len;
    logic        hit;
    case (k)
      KwClr:      txt = {"CLR", 48'h0};
      KwLoadDone: txt = {"LOAD", "_DONE"};
      KwStart:    txt = {"START", 32'h0};
      KwStop:     txt = {"STOP", 40'h0};
      KwData:     txt = {"DATA,", 32'h0};
      default:    txt = '0;
    endcase
    len = kw_len(k);
    sh  = txt << {p[3:0], 3'b000};
    hit = (p < {4'd0, len}) && (sh[71:64] == c);
    return hit;
  endfunction

endpackage

/* rtl/lcd_in_if.sv */
`timescale 1ns / 1ps
// Byte input channel of the line command decoder.
// Depends on lcd_pkg for field widths.
interface lcd_in_if;
  logic                      valid;
  logic                      ready;
  logic [lcd_pkg::ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

/* rtl/lcd_out_if.sv */
`timescale 1ns / 1ps
// Event output channel of the line command decoder.
// Depends on lcd_pkg for field widths.
interface lcd_out_if;
  logic                       valid;
  logic                       ready;
  logic [lcd_pkg::EventW-1:0] event_res;
  logic [lcd_pkg::ValW-1:0]   val_a;
  logic [lcd_pkg::ValW-1:0]   val_b;
  logic [lcd_pkg::ValW-1:0]   val_c;
  logic [lcd_pkg::ValW-1:0]   val_d;
  logic [lcd_pkg::ModeW-1:0]  mode_value;

  modport source (output valid, output event_res, output val_a, output val_b,
                  output val_c, output val_d, output mode_value, input ready);
  modport sink   (input valid, input event_res, input val_a, input val_b,
                  input val_c, input val_d, input mode_value, output ready);
endinterface

/* rtl/lcd_cfg_if.sv */
`timescale 1ns / 1ps
// Configuration write channel carrying the line limit.
// Depends on lcd_pkg for the register width.
interface lcd_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [lcd_pkg::LimitW-1:0] line_limit;

  modport source (output valid, output line_limit, input ready);
  modport sink   (input valid, input line_limit, output ready);
endinterface

/* rtl/line_command_decoder.sv */
`timescale 1ns / 1ps
// Line command decoder: emits an event word on each non-empty line end.
// A result word passes the input register and then the result register.
// Throughput: 1 byte per cycle unless the output stalls; the single-pass update
// between the registers sets it; a waiting word holds bytes in the input register.
// Reset: async active low; line state cleared, line limit set to 127.
// Depends on lcd_pkg, lcd_in_if, lcd_out_if, lcd_cfg_if.
module line_command_decoder #(
  parameter int unsigned LINE_STORE = lcd_pkg::LineStoreDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lcd_in_if.sink    in_if,
  lcd_out_if.source out_if,
  lcd_cfg_if.sink   cfg_if
);
  import lcd_pkg::*;

  localparam int unsigned PosW = $clog2(LINE_STORE);
  localparam logic [8:0] LimitCap = 9'(LINE_STORE - 1);

  // configuration
  logic [LimitW-1:0] line_limit_q;

  // input register
  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;

  // line state
  logic [PosW-1:0]      pos_q, pos_d;
  logic                 ovf_q, ovf_d;
  logic [NumKw-1:0]     mask_q, mask_d;
  logic [FieldIdxW-1:0] fld_q, fld_d;
  logic                 in_digits_q, in_digits_d;
  logic                 bad_q, bad_d;
  logic                 done_q, done_d;
  logic [ValW-1:0]      vals_q [NumFields];
  logic [ValW-1:0]      vals_d [NumFields];

  // result register
  logic            out_valid_q, out_valid_d;
  event_e          ev_q, ev_d;
  logic [ValW-1:0] va_q, va_d, vb_q, vb_d, vc_q, vc_d, vd_q, vd_d;
  logic [ModeW-1:0] mode_q, mode_d;

  logic       advance;
  logic       fire;
  logic       emit;
  logic [8:0] pos_x;
  logic [8:0] lim;
  logic [7:0] p8;
  logic       found;
  logic       is_digit;
  logic       data_ok;
  logic [ValW-1:0] prod;

  assign advance     = !out_valid_q || out_if.ready;
  assign fire        = in_valid_q && advance;
  assign in_if.ready = !in_valid_q || advance;
  assign cfg_if.ready = 1'b1;

  assign out_if.valid      = out_valid_q;
  assign out_if.event_res  = ev_q;
  assign out_if.val_a      = va_q;
  assign out_if.val_b      = vb_q;
  assign out_if.val_c      = vc_q;
  assign out_if.val_d      = vd_q;
  assign out_if.mode_value = mode_q;

  assign pos_x    = 9'(pos_q);
  assign p8       = 8'(pos_q);
  assign lim      = ({2'b00, line_limit_q} < LimitCap) ? {2'b00, line_limit_q} : LimitCap;
  assign is_digit = (in_byte_q >= ChZero) && (in_byte_q <= ChNine);
  assign prod     = (vals_q[fld_q] << 3) + (vals_q[fld_q] << 1)
                  + ValW'(in_byte_q - ChZero);
  assign data_ok  = !bad_q && (done_q || (fld_q == FieldIdxW'(4) && in_digits_q));

  always_comb begin
    pos_d       = pos_q;
    ovf_d       = ovf_q;
    mask_d      = mask_q;
    fld_d       = fld_q;
    in_digits_d = in_digits_q;
    bad_d       = bad_q;
    done_d      = done_q;
    vals_d      = vals_q;
    emit        = 1'b0;
    found       = 1'b0;
    ev_d        = EvUnknown;
    va_d        = '0;
    vb_d        = '0;
    vc_d        = '0;
    vd_d        = '0;
    mode_d      = '0;

    if (fire) begin
      if (in_byte_q == ChCr) begin
        // drop carriage return
      end else if (in_byte_q == ChLf) begin
        if (ovf_q) begin
          emit = 1'b1;
          ev_d = EvTooLong;
        end else if (pos_q != '0) begin
          emit = 1'b1;
          for (int k = 0; k < 4; k++) begin
            if (!found && mask_q[k] && pos_x == 9'(kw_len(kw_e'(k)))) begin
              ev_d  = event_e'(k);
              found = 1'b1;
            end
          end
          if (!found && mask_q[KwData] && pos_x >= 9'd5) begin
            if (data_ok) begin
              ev_d   = EvData;
              va_d   = vals_q[0];
              vb_d   = vals_q[1];
              vc_d   = vals_q[2];
              vd_d   = vals_q[3];
              mode_d = vals_q[4][ModeW-1:0];
            end else begin
              ev_d = EvBadData;
            end
          end
        end
        // every line end returns the line state to reset
        pos_d       = '0;
        ovf_d       = 1'b0;
        mask_d      = '1;
        fld_d       = '0;
        in_digits_d = 1'b0;
        bad_d       = 1'b0;
        done_d      = 1'b0;
        for (int i = 0; i < NumFields; i++) begin
          vals_d[i] = '0;
        end
      end else if (ovf_q || pos_x >= lim) begin
        ovf_d = 1'b1;
      end else begin
        for (int k = 0; k < 4; k++) begin
          if (mask_q[k] && !kw_hit(kw_e'(k), p8, in_byte_q)) begin
            mask_d[k] = 1'b0;
          end
        end
        if (mask_q[KwData]) begin
          if (pos_x < 9'd5) begin
            if (!kw_hit(KwData, p8, in_byte_q)) begin
              mask_d[KwData] = 1'b0;
            end
          end else if (!bad_q && !done_q) begin
            if (is_digit) begin
              if (fld_q < FieldIdxW'(NumFields)) begin
                vals_d[fld_q] = prod;
              end
              in_digits_d = 1'b1;
            end else if (!in_digits_q) begin
              if (in_byte_q != ChSpace && in_byte_q != ChTab) begin
                bad_d = 1'b1;
              end
            end else if (fld_q < FieldIdxW'(4)) begin
              if (in_byte_q == ChComma) begin
                fld_d       = fld_q + FieldIdxW'(1);
                in_digits_d = 1'b0;
              end else begin
                bad_d = 1'b1;
              end
            end else begin
              // ignore text after the fifth number
              done_d = 1'b1;
            end
          end
        end
        pos_d = pos_q + PosW'(1);
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = fire && emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_limit_q <= LimitReset;
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      pos_q        <= '0;
      ovf_q        <= 1'b0;
      mask_q       <= '1;
      fld_q        <= '0;
      in_digits_q  <= 1'b0;
      bad_q        <= 1'b0;
      done_q       <= 1'b0;
      for (int i = 0; i < NumFields; i++) begin
        vals_q[i] <= '0;
      end
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        line_limit_q <= cfg_if.line_limit;
      end
      if (in_if.valid && in_if.ready) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      out_valid_q <= out_valid_d;
      pos_q       <= pos_d;
      ovf_q       <= ovf_d;
      mask_q      <= mask_d;
      fld_q       <= fld_d;
      in_digits_q <= in_digits_d;
      bad_q       <= bad_d;
      done_q      <= done_d;
      vals_q      <= vals_d;
    end
  end

  // payload registers: load on accept or on an emitted word, hold otherwise
  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      in_byte_q <= in_if.rx_byte;
    end
    if (advance && fire && emit) begin
      ev_q   <= ev_d;
      va_q   <= va_d;
      vb_q   <= vb_d;
      vc_q   <= vc_d;
      vd_q   <= vd_d;
      mode_q <= mode_d;
    end
  end

endmodule
